// ----- design/mode7_scanline_affine_params_top_macros.svh -----
// Assertion macros for the mode 7 line parameter block and its checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MODE7_SCANLINE_AFFINE_PARAMS_TOP_MACROS_SVH
`define MODE7_SCANLINE_AFFINE_PARAMS_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define M7SA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define M7SA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/m7sa_pkg.sv -----
// Shared types, constants and trig table of the mode 7 line parameter block.
// No dependencies; the top level and the stage modules import it.
package m7sa_pkg;

  localparam int LAST_VISIBLE_LINE = 159;
  localparam int HORIZON_LINE      = 32;
  localparam int FOG_LAST_LINE     = 16 * 6;
  localparam int DIST_NUMERATOR    = (1 << 16);
  localparam int HALF_SCREEN_W     = 120;
  localparam int VIEW_DEPTH        = 128;
  localparam int QUARTER_TURN      = 64;

  // s / 6 as (s * 43) >> 8, exact for s below 128
  localparam int DIV6_MUL   = 43;
  localparam int DIV6_SHIFT = 8;

  localparam int LINE_W   = 8;
  localparam int DIST_W   = 7;                 // line distance below the horizon
  localparam int DIST_DEPTH = 1 << DIST_W;
  localparam int RECIP_W  = 17;                // 65536 / d, d >= 1
  localparam int HEIGHT_W = 14;
  localparam int LAM_SHIFT = 12;
  localparam int LAM_W    = RECIP_W + HEIGHT_W - LAM_SHIFT;
  localparam int TRIG_W   = 10;                // -256..256
  localparam int ROT_PROD_W = LAM_W + 1 + TRIG_W;
  localparam int ROT_W    = ROT_PROD_W - 8;    // lam * trig >>> 8
  localparam int POS_W    = 18;
  localparam int SCALE_W  = 16;
  localparam int ORIGIN_W = 28;

  typedef enum logic [1:0] {
    BG_KEEP    = 2'd0,
    BG_DISABLE = 2'd1,
    BG_ENABLE  = 2'd2
  } bg_action_e;

  typedef enum logic [1:0] {
    REG_CAMERA_X      = 2'd0,
    REG_CAMERA_Y      = 2'd1,
    REG_CAMERA_HEIGHT = 2'd2,
    REG_CAMERA_YAW    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic       write_active;
    bg_action_e bg_action;
    logic       fog_enable;
    logic [3:0] fog_level;
    logic       affine_valid;
  } line_ctl_t;

  localparam logic [8:0] QSINE [65] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
    9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
    9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
    9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
    9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
    9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
    9'd256
  };

  // Sine of a 256-step angle, amplitude 256, built from the quarter wave.
  function automatic logic signed [TRIG_W-1:0] sine_of(input logic [7:0] angle);
    logic [6:0] idx;
    logic [8:0] mag;
    logic signed [TRIG_W-1:0] v;
    if (angle[6]) begin
      idx = 7'd64 - {1'b0, angle[5:0]};
    end else begin
      idx = {1'b0, angle[5:0]};
    end
    mag = QSINE[idx];
    v = $signed({1'b0, mag});
    sine_of = angle[7] ? -v : v;
  endfunction

endpackage

// ----- design/mode7_scanline_affine_params_top.sv -----
// Top level of the mode 7 per-line parameter block: register port and pipeline.
// Depends on m7sa_pkg, m7sa_front, m7sa_rot and m7sa_orig.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------
//   config   | in        | psel/penable/pwrite    | paddr, pwdata -> prdata
//   line     | in        | in_valid_i/in_stall_o  | line_count_i
//   result   | out       | out_valid_o/out_stall_i| write_active .. origin_y
//
// One item per cycle sustained while out_stall_i is low; each item passes the stage 1 to 4 registers.
// The depth is set by the chain height * reciprocal, then scale * sin/cos, then
// the origin sums, each product held in a register before the next step.
// Reset clears the stage valid bits and loads the camera registers with their
// reset values. A stalled result holds in the output register while empty
// stages upstream keep filling; the input stalls only once all four are full.
module mode7_scanline_affine_params_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // line items in
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [m7sa_pkg::LINE_W-1:0]          line_count_i,
  // result items out
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 write_active_o,
  output logic [1:0]                           bg_action_o,
  output logic                                 fog_enable_o,
  output logic [3:0]                           fog_level_o,
  output logic                                 affine_valid_o,
  output logic signed [m7sa_pkg::SCALE_W-1:0]  scale_a_o,
  output logic signed [m7sa_pkg::SCALE_W-1:0]  scale_c_o,
  output logic signed [m7sa_pkg::ORIGIN_W-1:0] origin_x_o,
  output logic signed [m7sa_pkg::ORIGIN_W-1:0] origin_y_o
);
  import m7sa_pkg::*;

  // ---------------------------------------------------------------------------
  // Camera registers
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]    camera_x_q;
  logic [POS_W-1:0]    camera_y_q;
  logic [HEIGHT_W-1:0] camera_height_q;
  logic [7:0]          camera_yaw_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_x_q      <= POS_W'(55296);
      camera_y_q      <= POS_W'(61440);
      camera_height_q <= HEIGHT_W'(2048);
      camera_yaw_q    <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAMERA_X:      camera_x_q      <= pwdata[POS_W-1:0];
        REG_CAMERA_Y:      camera_y_q      <= pwdata[POS_W-1:0];
        REG_CAMERA_HEIGHT: camera_height_q <= pwdata[HEIGHT_W-1:0];
        REG_CAMERA_YAW:    camera_yaw_q    <= pwdata[7:0];
        default:           camera_yaw_q    <= camera_yaw_q;
      endcase
    end
  end

  // Read back: zero-extend the addressed register.
  always_comb begin
    unique case (cfg_idx)
      REG_CAMERA_X:      prdata = 32'(camera_x_q);
      REG_CAMERA_Y:      prdata = 32'(camera_y_q);
      REG_CAMERA_HEIGHT: prdata = 32'(camera_height_q);
      REG_CAMERA_YAW:    prdata = 32'(camera_yaw_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage takes a new item when it is empty or the
  // stage after it moves on in the same cycle, so bubbles close up under stall.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld1 = rdy1 && in_valid_i;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign ld4 = rdy4 && v3_q;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  line_ctl_t                ctl1, ctl3, ctl4;
  logic [RECIP_W-1:0]       recip1;
  logic signed [TRIG_W-1:0] sin1, cos1;
  logic signed [ROT_W-1:0]  lc3, ls3;

  // Stage 1: decode the line, look up the reciprocal of its distance and sin/cos.
  m7sa_front u_front (
    .clk_i        (clk_i),
    .ld_i         (ld1),
    .line_count_i (line_count_i),
    .camera_yaw_i (camera_yaw_q),
    .ctl_o        (ctl1),
    .recip_o      (recip1),
    .sin_o        (sin1),
    .cos_o        (cos1)
  );

  // Stages 2 and 3: scale by height, then rotate by yaw.
  m7sa_rot u_rot (
    .clk_i           (clk_i),
    .ld2_i           (ld2),
    .ld3_i           (ld3),
    .ctl_i           (ctl1),
    .recip_i         (recip1),
    .sin_i           (sin1),
    .cos_i           (cos1),
    .camera_height_i (camera_height_q),
    .ctl_o           (ctl3),
    .lc_o            (lc3),
    .ls_o            (ls3)
  );

  // Stage 4: origin sums into the result register.
  m7sa_orig u_orig (
    .clk_i      (clk_i),
    .ld_i       (ld4),
    .ctl_i      (ctl3),
    .lc_i       (lc3),
    .ls_i       (ls3),
    .camera_x_i (camera_x_q),
    .camera_y_i (camera_y_q),
    .ctl_o      (ctl4),
    .scale_a_o  (scale_a_o),
    .scale_c_o  (scale_c_o),
    .origin_x_o (origin_x_o),
    .origin_y_o (origin_y_o)
  );

  assign write_active_o = ctl4.write_active;
  assign bg_action_o    = 2'(ctl4.bg_action);
  assign fog_enable_o   = ctl4.fog_enable;
  assign fog_level_o    = ctl4.fog_level;
  assign affine_valid_o = ctl4.affine_valid;

endmodule

// ----- design/m7sa_front.sv -----
// Stage 1: line decode, fog and background action, reciprocal and trig lookup.
// Depends on m7sa_pkg.
module m7sa_front (
  input  logic                                clk_i,
  input  logic                                ld_i,
  input  logic [m7sa_pkg::LINE_W-1:0]         line_count_i,
  input  logic [7:0]                          camera_yaw_i,
  output m7sa_pkg::line_ctl_t                 ctl_o,
  output logic [m7sa_pkg::RECIP_W-1:0]        recip_o,
  output logic signed [m7sa_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [m7sa_pkg::TRIG_W-1:0]  cos_o
);
  import m7sa_pkg::*;

  logic [RECIP_W-1:0] recip_tbl [DIST_DEPTH];

  // 65536 / d, folded at elaboration; entry zero is read only for lines without affine values
  for (genvar g = 0; g < DIST_DEPTH; g++) begin : g_recip
    if (g == 0) begin : g_zero
      assign recip_tbl[g] = '0;
    end else begin : g_div
      localparam int Q = DIST_NUMERATOR / g;
      assign recip_tbl[g] = RECIP_W'(Q);
    end
  end

  logic [LINE_W-1:0] s;
  logic              visible;
  logic [DIST_W-1:0] horizon_dist;
  logic [13:0]       div6_prod;
  logic [5:0]        s_div6;
  line_ctl_t         ctl_d;

  assign s            = line_count_i - LINE_W'(1);
  assign visible      = (line_count_i != '0) && (s <= LINE_W'(LAST_VISIBLE_LINE));
  assign horizon_dist = DIST_W'(s - LINE_W'(HORIZON_LINE));
  assign div6_prod    = 14'(s) * 14'(DIV6_MUL);
  assign s_div6       = div6_prod[DIV6_SHIFT +: 6];

  always_comb begin
    ctl_d = '0;
    ctl_d.bg_action = BG_KEEP;
    if (visible) begin
      ctl_d.write_active = 1'b1;
      priority if (s < LINE_W'(HORIZON_LINE)) begin
        ctl_d.bg_action  = BG_DISABLE;
        ctl_d.fog_enable = 1'b1;
        ctl_d.fog_level  = s[4:1];
      end else begin
        if (s == LINE_W'(HORIZON_LINE)) begin
          ctl_d.bg_action = BG_ENABLE;
        end
        if (s <= LINE_W'(FOG_LAST_LINE)) begin
          ctl_d.fog_enable = 1'b1;
          ctl_d.fog_level  = 4'(6'd16 - s_div6);
        end
        ctl_d.affine_valid = (s > LINE_W'(HORIZON_LINE));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      ctl_o   <= ctl_d;
      recip_o <= recip_tbl[horizon_dist];
      sin_o   <= sine_of(camera_yaw_i);
      cos_o   <= sine_of(camera_yaw_i + 8'(QUARTER_TURN));
    end
  end

endmodule

// ----- design/m7sa_rot.sv -----
// Stages 2 and 3: line scale from height and reciprocal, then rotation by yaw.
// Depends on m7sa_pkg.
module m7sa_rot (
  input  logic                                 clk_i,
  input  logic                                 ld2_i,
  input  logic                                 ld3_i,
  input  m7sa_pkg::line_ctl_t                  ctl_i,
  input  logic [m7sa_pkg::RECIP_W-1:0]         recip_i,
  input  logic signed [m7sa_pkg::TRIG_W-1:0]   sin_i,
  input  logic signed [m7sa_pkg::TRIG_W-1:0]   cos_i,
  input  logic [m7sa_pkg::HEIGHT_W-1:0]        camera_height_i,
  output m7sa_pkg::line_ctl_t                  ctl_o,
  output logic signed [m7sa_pkg::ROT_W-1:0]    lc_o,
  output logic signed [m7sa_pkg::ROT_W-1:0]    ls_o
);
  import m7sa_pkg::*;

  logic [RECIP_W+HEIGHT_W-1:0] lam_prod;
  logic [LAM_W-1:0]            lam_q;
  logic signed [TRIG_W-1:0]    sin_q;
  logic signed [TRIG_W-1:0]    cos_q;
  line_ctl_t                   ctl_q;
  logic signed [ROT_PROD_W-1:0] lc_prod;
  logic signed [ROT_PROD_W-1:0] ls_prod;

  assign lam_prod = (RECIP_W+HEIGHT_W)'(camera_height_i) * (RECIP_W+HEIGHT_W)'(recip_i);

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      lam_q <= lam_prod[LAM_SHIFT +: LAM_W];
      sin_q <= sin_i;
      cos_q <= cos_i;
      ctl_q <= ctl_i;
    end
  end

  assign lc_prod = ROT_PROD_W'($signed({1'b0, lam_q})) * ROT_PROD_W'(cos_q);
  assign ls_prod = ROT_PROD_W'($signed({1'b0, lam_q})) * ROT_PROD_W'(sin_q);

  // drop the 8 fraction bits of the trig amplitude (floor)
  always_ff @(posedge clk_i) begin
    if (ld3_i) begin
      lc_o  <= lc_prod[ROT_PROD_W-1:8];
      ls_o  <= ls_prod[ROT_PROD_W-1:8];
      ctl_o <= ctl_q;
    end
  end

endmodule

// ----- design/m7sa_orig.sv -----
// Stage 4: affine steps and line origin, zeroed where not written; result register.
// Depends on m7sa_pkg.
module m7sa_orig (
  input  logic                                 clk_i,
  input  logic                                 ld_i,
  input  m7sa_pkg::line_ctl_t                  ctl_i,
  input  logic signed [m7sa_pkg::ROT_W-1:0]    lc_i,
  input  logic signed [m7sa_pkg::ROT_W-1:0]    ls_i,
  input  logic [m7sa_pkg::POS_W-1:0]           camera_x_i,
  input  logic [m7sa_pkg::POS_W-1:0]           camera_y_i,
  output m7sa_pkg::line_ctl_t                  ctl_o,
  output logic signed [m7sa_pkg::SCALE_W-1:0]  scale_a_o,
  output logic signed [m7sa_pkg::SCALE_W-1:0]  scale_c_o,
  output logic signed [m7sa_pkg::ORIGIN_W-1:0] origin_x_o,
  output logic signed [m7sa_pkg::ORIGIN_W-1:0] origin_y_o
);
  import m7sa_pkg::*;

  logic signed [ROT_W-5:0] pa;
  logic signed [ROT_W-5:0] pc;
  logic signed [31:0]      pa_w;
  logic signed [31:0]      pc_w;
  logic signed [31:0]      lc_w;
  logic signed [31:0]      ls_w;
  logic signed [31:0]      ox_w;
  logic signed [31:0]      oy_w;

  assign pa   = lc_i[ROT_W-1:4];
  assign pc   = ls_i[ROT_W-1:4];
  assign pa_w = 32'(pa);
  assign pc_w = 32'(pc);
  assign lc_w = 32'(lc_i);
  assign ls_w = 32'(ls_i);

  assign ox_w = $signed({14'd0, camera_x_i}) - HALF_SCREEN_W * pa_w
                + ((VIEW_DEPTH * ls_w) >>> 4);
  assign oy_w = $signed({14'd0, camera_y_i}) - HALF_SCREEN_W * pc_w
                - ((VIEW_DEPTH * lc_w) >>> 4);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      ctl_o <= ctl_i;
      if (ctl_i.affine_valid) begin
        scale_a_o  <= pa[SCALE_W-1:0];
        scale_c_o  <= pc[SCALE_W-1:0];
        origin_x_o <= ox_w[ORIGIN_W-1:0];
        origin_y_o <= oy_w[ORIGIN_W-1:0];
      end else begin
        scale_a_o  <= '0;
        scale_c_o  <= '0;
        origin_x_o <= '0;
        origin_y_o <= '0;
      end
    end
  end

endmodule

// ----- design/m7sa_checker.sv -----
// Port-level checks for the mode 7 line parameter block, bound to its top level.
// Depends on the macro header mode7_scanline_affine_params_top_macros.svh.
`include "mode7_scanline_affine_params_top_macros.svh"

module m7sa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_active_o,
  input logic [1:0]  bg_action_o,
  input logic        fog_enable_o,
  input logic [3:0]  fog_level_o,
  input logic        affine_valid_o,
  input logic signed [15:0] scale_a_o,
  input logic signed [15:0] scale_c_o,
  input logic signed [27:0] origin_x_o,
  input logic signed [27:0] origin_y_o
);

  // Hold a stalled result.
  `M7SA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(origin_x_o) && $stable(origin_y_o) && $stable(scale_a_o) && $stable(bg_action_o), "stalled result changed")

  // An invisible line carries nothing but zeros.
  `M7SA_ASSERT_NOW(a_invisible_zero, out_valid_o && !write_active_o, bg_action_o == 2'd0 && !fog_enable_o && !affine_valid_o, "invisible line has nonzero fields")

  // Affine fields are zero unless written.
  `M7SA_ASSERT_NOW(a_affine_zero, out_valid_o && !affine_valid_o, scale_a_o == '0 && scale_c_o == '0 && origin_x_o == '0 && origin_y_o == '0, "unwritten affine fields nonzero")

  // Fog level is zero with fog off.
  `M7SA_ASSERT_NOW(a_fog_zero, out_valid_o && !fog_enable_o, fog_level_o == 4'd0, "fog level without fog")

  // Affine lines lie below the horizon: background already enabled, not touched.
  `M7SA_ASSERT_NOW(a_affine_line, out_valid_o && affine_valid_o, write_active_o && bg_action_o == 2'd0, "affine values on a sky or invisible line")

endmodule

bind mode7_scanline_affine_params_top m7sa_checker u_m7sa_checker (.*);
